// ===== rtl/psl_pkg.sv =====
package psl_pkg;

  // Storage geometry.
  localparam int DEPTH       = 16;
  localparam int ENTRY_WIDTH = 32;

  // Fixed field widths of the channels.
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 5;
  localparam int DATA_W  = 32;
  localparam int FILL_W  = 5;

  // Derived widths.
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W   = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

  typedef logic [ENTRY_WIDTH-1:0] entry_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  // Operation codes of the input channel.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 3'd0,
    FUNC_INSERT = 3'd1,
    FUNC_DELETE = 3'd2,
    FUNC_READ   = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  // What the cell row does at each clock edge.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cell_cmd_e;

  // Command broadcast to every cell.
  typedef struct packed {
    cell_cmd_e cmd;
    count_t    target; // 0-based slot that is loaded or removed
    count_t    count;  // fill count before the operation
  } cell_ctrl_t;

  // Keep the low ENTRY_WIDTH bits of an input value.
  function automatic entry_t to_entry(logic [DATA_W-1:0] d);
    entry_t e;
    e = '0;
    for (int b = 0; b < ENTRY_WIDTH; b++) begin
      if (b < DATA_W) begin
        e[b] = d[b];
      end
    end
    return e;
  endfunction

  // Place an entry into the output data field, zero extended.
  function automatic logic [DATA_W-1:0] from_entry(entry_t e);
    logic [DATA_W-1:0] d;
    d = '0;
    for (int b = 0; b < DATA_W; b++) begin
      if (b < ENTRY_WIDTH) begin
        d[b] = e[b];
      end
    end
    return d;
  endfunction

  // Fit the internal count into the fill count field.
  function automatic logic [FILL_W-1:0] to_fill(count_t c);
    logic [FILL_W-1:0] f;
    f = '0;
    for (int b = 0; b < FILL_W; b++) begin
      if (b < COUNT_W) begin
        f[b] = c[b];
      end
    end
    return f;
  endfunction

endpackage

// ===== rtl/psl_if.sv =====
// Request channel: one list operation per transfer.
interface psl_in_if;
  import psl_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [POS_W-1:0]   position;
  logic [DATA_W-1:0]  entry_data;

  modport source (output valid, func, position, entry_data, input ready);
  modport sink   (input valid, func, position, entry_data, output ready);
endinterface

// Result channel: one result per request.
interface psl_out_if;
  import psl_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic               accepted;
  logic [FILL_W-1:0]  fill_count;

  modport source (output valid, read_data, accepted, fill_count, input ready);
  modport sink   (input valid, read_data, accepted, fill_count, output ready);
endinterface

// ===== rtl/psl_cell.sv =====
// One slot of the list. It loads a new entry, takes its left or right
// neighbor's entry, or holds, as the broadcast command asks.
module psl_cell (
  input  logic                clk_i,
  input  psl_pkg::cell_ctrl_t ctrl_i,
  input  psl_pkg::count_t     slot_i,
  input  psl_pkg::entry_t     new_i,
  input  psl_pkg::entry_t     left_i,
  input  psl_pkg::entry_t     right_i,
  output psl_pkg::entry_t     entry_o
);
  import psl_pkg::*;

  entry_t entry_q, entry_d;
  cmp_t   slot_next;

  assign slot_next = {1'b0, slot_i} + cmp_t'(1);

  // Select the next content of this slot.
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      CMD_APPEND: begin
        if (slot_i == ctrl_i.target) begin
          entry_d = new_i;
        end
      end
      CMD_INSERT: begin
        if (slot_i == ctrl_i.target) begin
          entry_d = new_i;
        end else if (slot_i > ctrl_i.target && slot_i <= ctrl_i.count) begin
          entry_d = left_i;
        end
      end
      CMD_DELETE: begin
        if (slot_i >= ctrl_i.target && slot_next < {1'b0, ctrl_i.count}) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Entry storage; contents are defined only once written.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/positional_shift_list_unit.sv =====
// Channel  Port    Direction  Payload
// -------  ------  ---------  ---------------------------------------
// request  in_i    sink       func, position, entry_data
// result   out_o   source     read_data, accepted, fill_count
//
// The row of cells shifts all entries at once, and the result is registered,
// so a request may follow each cycle while the result side is not stalled.
// A transfer is taken whenever the result register is empty or drains in
// the same cycle; a stalled result holds the request side.
// Reset clears the fill count and the result valid; entries need no reset.
module positional_shift_list_unit (
  input logic clk_i,
  input logic rst_ni,
  psl_in_if.sink    in_i,
  psl_out_if.source out_o
);
  import psl_pkg::*;

  count_t             count_q, count_d;
  logic               out_valid_q;
  logic [DATA_W-1:0]  rdata_q, rdata_d;
  logic               ok_q, ok_d;
  logic [FILL_W-1:0]  fill_q;
  logic               take;
  cell_ctrl_t         ctrl;
  entry_t             new_entry;
  entry_t             entries [DEPTH];
  cmp_t               pos_w, cnt_w, pos_m1;
  logic               not_full, ins_ok, hit_ok;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign new_entry  = to_entry(in_i.entry_data);

  // Position checks against the current fill count.
  assign pos_w    = cmp_t'(in_i.position);
  assign cnt_w    = cmp_t'(count_q);
  assign pos_m1   = pos_w - cmp_t'(1);
  assign not_full = count_q < count_t'(DEPTH);
  assign ins_ok   = not_full && pos_w >= cmp_t'(1) && pos_w <= cnt_w + cmp_t'(1);
  assign hit_ok   = pos_w >= cmp_t'(1) && pos_w <= cnt_w;

  // Decode the operation into a cell command and a result.
  always_comb begin
    ctrl.cmd    = CMD_HOLD;
    ctrl.target = pos_m1[COUNT_W-1:0];
    ctrl.count  = count_q;
    count_d     = count_q;
    ok_d        = 1'b0;
    rdata_d     = '0;
    case (func_e'(in_i.func))
      FUNC_APPEND: begin
        ctrl.target = count_q;
        if (not_full) begin
          ctrl.cmd = CMD_APPEND;
          count_d  = count_q + count_t'(1);
          ok_d     = 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (ins_ok) begin
          ctrl.cmd = CMD_INSERT;
          count_d  = count_q + count_t'(1);
          ok_d     = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (hit_ok) begin
          ctrl.cmd = CMD_DELETE;
          count_d  = count_q - count_t'(1);
          ok_d     = 1'b1;
        end
      end
      FUNC_READ: begin
        if (hit_ok) begin
          rdata_d = from_entry(entries[pos_m1[IDX_W-1:0]]);
          ok_d    = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        count_d = '0;
        ok_d    = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (!take) begin
      ctrl.cmd = CMD_HOLD;
    end
  end

  // Row of cells, each wired to its neighbors.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = entries[g+1];
    end
    psl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .slot_i  (count_t'(g)),
      .new_i   (new_entry),
      .left_i  (left),
      .right_i (right),
      .entry_o (entries[g])
    );
  end

  // Fill count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      rdata_q <= rdata_d;
      ok_q    <= ok_d;
      fill_q  <= to_fill(count_d);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = rdata_q;
  assign out_o.accepted   = ok_q;
  assign out_o.fill_count = fill_q;

endmodule

// ===== dv/psl_checker.sv =====
// Watches both channels of the list unit, keeps a mirror of the list,
// and compares every result transfer with the oldest predicted result.
module psl_checker (
  input  logic clk_i,
  input  logic rst_ni,
  psl_in_if    req,
  psl_out_if   res,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count,
  output int   rejected_count,
  output int   list_fill
);
  timeunit 1ns;
  timeprecision 1ps;
  import psl_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              accepted;
    logic [FILL_W-1:0] fill_count;
  } list_result_t;

  // Mirror of the list contents and its fill count.
  logic [ENTRY_WIDTH-1:0] list_mirror [DEPTH];
  int                     mirror_count;

  // Results predicted for accepted requests, oldest first.
  list_result_t predicted_results [$];

  assign list_fill = mirror_count;

  // One line per mismatch, and the failure count goes up.
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
             $time, what, got, want);
    fail_count++;
  endtask

  // Apply one list operation to the mirror and return its result.
  function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] f,
                                                 input logic [POS_W-1:0]  pos,
                                                 input logic [DATA_W-1:0] d);
    list_result_t r;
    int           p;
    r = '0;
    p = int'(pos);
    case (f)
      FUNC_APPEND: begin
        if (mirror_count < DEPTH) begin
          list_mirror[mirror_count] = d[ENTRY_WIDTH-1:0];
          mirror_count++;
          r.accepted = 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (mirror_count < DEPTH && p >= 1 && p <= mirror_count + 1) begin
          for (int i = mirror_count; i > p - 1; i--) begin
            list_mirror[i] = list_mirror[i-1];
          end
          list_mirror[p-1] = d[ENTRY_WIDTH-1:0];
          mirror_count++;
          r.accepted = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (p >= 1 && p <= mirror_count) begin
          for (int i = p - 1; i + 1 < mirror_count; i++) begin
            list_mirror[i] = list_mirror[i+1];
          end
          mirror_count--;
          r.accepted = 1'b1;
        end
      end
      FUNC_READ: begin
        if (p >= 1 && p <= mirror_count) begin
          r.read_data[ENTRY_WIDTH-1:0] = list_mirror[p-1];
          r.accepted = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        mirror_count = 0;
        r.accepted = 1'b1;
      end
      default: begin
      end
    endcase
    r.fill_count = FILL_W'(mirror_count);
    return r;
  endfunction

  // Compare result transfers first, then record the request transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      mirror_count = 0;
      predicted_results.delete();
      fail_count = 0;
      pending_count = 0;
      checked_count = 0;
      rejected_count = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (predicted_results.size() == 0) begin
          flag_mismatch("result with nothing pending",
                        {res.read_data, res.accepted, res.fill_count}, '0);
        end else begin
          want = predicted_results.pop_front();
          if (res.read_data !== want.read_data) begin
            flag_mismatch("read_data", res.read_data, want.read_data);
          end
          if (res.accepted !== want.accepted) begin
            flag_mismatch("accepted", res.accepted, want.accepted);
          end
          if (res.fill_count !== want.fill_count) begin
            flag_mismatch("fill_count", res.fill_count, want.fill_count);
          end
          if (!want.accepted) begin
            rejected_count++;
          end
          checked_count++;
        end
      end
      if (req.valid && req.ready) begin
        predicted_results.push_back(apply_list_op(req.func, req.position,
                                                  req.entry_data));
      end
      pending_count = predicted_results.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Drives list operations into the unit with random gaps and result stalls,
// and gives the verdict from the checker's failure count.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import psl_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 150;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 103;
  localparam int DRAIN_CYCLES   = 4;

  // Codes the unit does not define; it must ignore them.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  int fail_count;
  int pending_count;
  int checked_count;
  int rejected_count;
  int list_fill;

  int   send_idle_pct;
  int   recv_stall_pct;
  logic long_hold_req;
  int   op_tally [8];
  int   full_hits;
  int   idle_cycles;

  psl_in_if  req_if ();
  psl_out_if res_if ();

  positional_shift_list_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  psl_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req            (req_if),
    .res            (res_if),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .rejected_count (rejected_count),
    .list_fill      (list_fill)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_op(input logic [FUNC_W-1:0] f, input int pos,
                         input logic [DATA_W-1:0] d);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if ((f == FUNC_APPEND || f == FUNC_INSERT) && list_fill == DEPTH) begin
      full_hits++;
    end
    op_tally[f]++;
    req_if.valid      <= 1'b1;
    req_if.func       <= f;
    req_if.position   <= POS_W'(pos);
    req_if.entry_data <= d;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Operation weights lean toward growing or shrinking the list.
  function automatic logic [FUNC_W-1:0] pick_func(input op_mix_e mix);
    int w_app, w_ins, w_del, w_rd, w_clr;
    int r;
    case (mix)
      MIX_GROW:   begin w_app = 35; w_ins = 35; w_del = 10; w_rd = 15; w_clr = 1; end
      MIX_SHRINK: begin w_app = 10; w_ins = 10; w_del = 45; w_rd = 30; w_clr = 1; end
      default:    begin w_app = 22; w_ins = 22; w_del = 22; w_rd = 28; w_clr = 2; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_app) return FUNC_APPEND;
    r -= w_app;
    if (r < w_ins) return FUNC_INSERT;
    r -= w_ins;
    if (r < w_del) return FUNC_DELETE;
    r -= w_del;
    if (r < w_rd) return FUNC_READ;
    r -= w_rd;
    if (r < w_clr) return FUNC_CLEAR;
    case ($urandom_range(0, 2))
      0:       return FUNC_SPARE_A;
      1:       return FUNC_SPARE_B;
      default: return FUNC_SPARE_C;
    endcase
  endfunction

  // Result side: random stalls, plus one long hold when asked for.
  initial begin
    int hold;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      hold = 0;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_if.ready <= 1'b0;
        hold = LONG_HOLD;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        res_if.ready <= 1'b0;
        hold = pick_gap();
      end else begin
        res_if.ready <= 1'b1;
      end
      repeat (hold) @(negedge clk_i);
    end
  end

  // Ends the run when no transfer happens for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    op_mix_e          mix;
    logic [FUNC_W-1:0] f;
    logic [DATA_W-1:0] d;
    int               pos;
    int               sent;
    int               r;

    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.func       = FUNC_APPEND;
    req_if.position   = '0;
    req_if.entry_data = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    long_hold_req     = 1'b0;
    full_hits         = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-list rejects, edge positions and data, spare codes.
    send_op(FUNC_READ,   1, 32'h0);
    send_op(FUNC_DELETE, 1, 32'h0);
    send_op(FUNC_INSERT, 2, 32'hDEAD_BEEF);
    send_op(FUNC_INSERT, 1, 32'hFFFF_FFFF);
    send_op(FUNC_APPEND, 0, 32'h0000_0000);
    send_op(FUNC_INSERT, 3, 32'hA5A5_5A5A);
    send_op(FUNC_INSERT, 1, 32'h5A5A_A5A5);
    send_op(FUNC_READ,   0, 32'h0);
    send_op(FUNC_READ,   1, 32'hFFFF_FFFF);
    send_op(FUNC_READ,   4, 32'h0);
    send_op(FUNC_READ,   5, 32'h0);
    send_op(FUNC_READ,   31, 32'h0);
    send_op(FUNC_DELETE, 5, 32'h0);
    send_op(FUNC_DELETE, 0, 32'h0);
    send_op(FUNC_DELETE, 2, 32'h0);
    send_op(FUNC_DELETE, 3, 32'h0);
    send_op(FUNC_SPARE_A, 1, 32'h1234_5678);
    send_op(FUNC_SPARE_B, 1, 32'h1234_5678);
    send_op(FUNC_SPARE_C, 1, 32'h1234_5678);
    send_op(FUNC_CLEAR,  0, 32'h0);
    send_op(FUNC_CLEAR,  0, 32'h0);

    // Random phases with changing operation mixes and idle rates.
    for (int ph = 0; ph < PHASES; ph++) begin
      mix = (ph % 3 == 0) ? MIX_GROW : ((ph % 3 == 1) ? MIX_SHRINK : MIX_EVEN);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 30; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 30; end
        default: begin send_idle_pct = 40; recv_stall_pct = 40; end
      endcase
      if (ph == 3) begin
        // Back pressure: the sender keeps offering through the long hold.
        send_idle_pct = 0;
        long_hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        f = pick_func(mix);
        if ($urandom_range(0, 9) < 8) begin
          if (f == FUNC_INSERT) begin
            pos = $urandom_range(1, list_fill + 1);
          end else begin
            pos = $urandom_range(1, (list_fill > 0) ? list_fill : 1);
          end
        end else begin
          pos = $urandom_range(0, 31);
        end
        r = $urandom_range(0, 9);
        d = (r == 0) ? '0 : ((r == 1) ? '1 : DATA_W'($urandom));
        send_op(f, pos, d);
        if (f <= FUNC_CLEAR) begin
          sent++;
        end
      end
    end
    req_if.valid <= 1'b0;

    // Drain the result side, then allow for the unit's latency.
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_count != 0) begin
      $display("%0d expected results never arrived", pending_count);
    end

    $display("Covered %0d appends, %0d inserts, %0d deletes, %0d reads, %0d clears,",
             op_tally[FUNC_APPEND], op_tally[FUNC_INSERT], op_tally[FUNC_DELETE],
             op_tally[FUNC_READ], op_tally[FUNC_CLEAR]);
    $display("  %0d spare codes; compared %0d results (%0d rejected),",
             op_tally[FUNC_SPARE_A] + op_tally[FUNC_SPARE_B] + op_tally[FUNC_SPARE_C],
             checked_count, rejected_count);
    $display("  %0d adds on a full list, one %0d-cycle hold", full_hits, LONG_HOLD);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/psl_pkg.sv
rtl/psl_if.sv
rtl/psl_cell.sv
rtl/positional_shift_list_unit.sv
dv/psl_checker.sv
dv/tb_top.sv
